@@ rtl/mrc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package mrc_pkg;

    localparam int MAX_FRAME_BYTES = 256;
    localparam int INDEX_CAP_INT   = (MAX_FRAME_BYTES - 1 > 255) ? 255 : MAX_FRAME_BYTES - 1;
    localparam logic [7:0] INDEX_CAP = INDEX_CAP_INT[7:0];

    localparam logic [15:0] CRC_POLY          = 16'hA001;
    localparam logic [15:0] CRC_SEED          = 16'hFFFF;
    localparam logic [7:0]  FUNC_MASK         = 8'h7F;
    localparam logic [7:0]  EXC_BIT           = 8'h80;
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [7:0]  EXPECTED_DEV_RST  = 8'h01;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [2:0] STATUS_OK        = 3'd0;
    localparam logic [2:0] STATUS_DEV_MISS  = 3'd1;
    localparam logic [2:0] STATUS_BAD_FUNC  = 3'd2;
    localparam logic [2:0] STATUS_CRC_ERR   = 3'd3;
    localparam logic [2:0] STATUS_SHORT     = 3'd4;
    localparam logic [2:0] STATUS_EXCEPTION = 3'd5;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] data_byte;
        logic [2:0] status;
        logic [6:0] function_code;
        logic [7:0] exception_code;
        logic [7:0] device_addr;
    } out_item_t;

    // one byte of reflected crc-16, bit by bit
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    function automatic logic function_supported(input logic [6:0] f);
        logic ok;
        case (f) inside
            7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6, 7'd7, 7'd15, 7'd16, 7'd17, 7'd22: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

endpackage

`default_nettype wire

@@ rtl/modbus_rtu_response_checker_top.sv @@
// channel   direction  handshake              payload
// cfg       in         cfg_valid / cfg_ready  cfg_data (expected device address)
// in        in         in_valid / in_ready    in_data  (rx byte, frame end)
// out       out        out_valid / out_ready  out_data (data byte or frame status)
//
// one byte per cycle sustained while out is not stalled: input register, then
// crc-16 byte step and frame checks in one pass into a two-entry output stage
// each result passes the input register and then the output stage; cfg is always ready
// reset clears the frame state, the crc to its seed and the expected device to 1
// a stalled output fills the skid entry, then a pending result drops in_ready
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_response_checker_top (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic [7:0]         cfg_data,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire mrc_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mrc_pkg::out_item_t      out_data
);
    import mrc_pkg::*;

    logic      res_valid;
    logic      res_ready;
    out_item_t res_data;

    assign cfg_ready = 1'b1;

    mrc_frame_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    mrc_out_skid u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (res_valid),
        .push_ready (res_ready),
        .push_data  (res_data),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

endmodule

`default_nettype wire

@@ rtl/mrc_frame_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mrc_frame_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [7:0]        cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire mrc_pkg::in_item_t in_data,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output mrc_pkg::out_item_t     res_data
);
    import mrc_pkg::*;

    logic        a_valid_reg, a_valid_next;
    in_item_t    a_item_reg;
    logic [7:0]  expected_device_reg;
    logic [7:0]  byte_index_reg, byte_index_next;
    logic [15:0] crc_reg, crc_next;
    logic [7:0]  seen_device_reg, seen_device_next;
    logic [7:0]  seen_function_reg, seen_function_next;
    logic [7:0]  seen_count_reg, seen_count_next;

    logic        a_fire;
    logic        at_cap;
    logic        is_data;
    logic        short_base;
    logic        short_exc;
    logic [7:0]  b;
    logic [2:0]  status_val;
    logic [7:0]  exc_val;

    assign b      = a_item_reg.rx_byte;
    assign at_cap = byte_index_reg >= INDEX_CAP;

    // the current byte lands in the seen fields before the checks
    always_comb
    begin
        seen_device_next   = seen_device_reg;
        seen_function_next = seen_function_reg;
        seen_count_next    = seen_count_reg;
        unique case (byte_index_reg)
            8'd0:    seen_device_next   = b;
            8'd1:    seen_function_next = b;
            8'd2:    seen_count_next    = b;
            default: ;
        endcase
    end

    assign crc_next = crc16_byte(crc_reg, b);

    assign is_data = !at_cap && (seen_function_next == FUNC_READ_HOLDING)
                     && (byte_index_reg >= 8'd3)
                     && ((byte_index_reg - 8'd3) < seen_count_next);

    // a capped frame counts as max length, which is never short
    assign short_base = !at_cap && (byte_index_reg < 8'd3);
    assign short_exc  = !at_cap && (byte_index_reg < 8'd4);

    always_comb
    begin
        exc_val = 8'h00;
        if (short_base)
            status_val = STATUS_SHORT;
        else if (seen_device_next != expected_device_reg)
            status_val = STATUS_DEV_MISS;
        else if (!function_supported(seen_function_next[6:0]))
            status_val = STATUS_BAD_FUNC;
        else if (crc_next != 16'h0000)
            status_val = STATUS_CRC_ERR;
        else if ((seen_function_next & EXC_BIT) != 8'h00)
        begin
            if (short_exc)
                status_val = STATUS_SHORT;
            else
            begin
                status_val = STATUS_EXCEPTION;
                exc_val    = seen_count_next;
            end
        end
        else
            status_val = STATUS_OK;
    end

    always_comb
    begin
        res_valid = a_valid_reg && (a_item_reg.frame_end || is_data);
        res_data.result_kind    = a_item_reg.frame_end ? KIND_STATUS : KIND_DATA;
        res_data.data_byte      = a_item_reg.frame_end ? 8'h00 : b;
        res_data.status         = a_item_reg.frame_end ? status_val : STATUS_OK;
        res_data.function_code  = seen_function_next[6:0] & FUNC_MASK[6:0];
        res_data.exception_code = a_item_reg.frame_end ? exc_val : 8'h00;
        res_data.device_addr    = seen_device_next;
    end

    assign a_fire   = a_valid_reg && (!res_valid || res_ready);
    assign in_ready = !a_valid_reg || a_fire;

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (in_valid && in_ready)
            a_valid_next = 1'b1;
        else if (a_fire)
            a_valid_next = 1'b0;
    end

    always_comb
    begin
        byte_index_next = byte_index_reg;
        if (a_item_reg.frame_end)
            byte_index_next = 8'd0;
        else if (!at_cap)
            byte_index_next = byte_index_reg + 8'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg         <= 1'b0;
            expected_device_reg <= EXPECTED_DEV_RST;
            byte_index_reg      <= 8'd0;
            crc_reg             <= CRC_SEED;
            seen_device_reg     <= 8'h00;
            seen_function_reg   <= 8'h00;
            seen_count_reg      <= 8'h00;
        end
        else
        begin
            a_valid_reg <= a_valid_next;
            if (cfg_we)
                expected_device_reg <= cfg_data;
            if (a_fire)
            begin
                byte_index_reg <= byte_index_next;
                if (a_item_reg.frame_end)
                begin
                    crc_reg           <= CRC_SEED;
                    seen_device_reg   <= 8'h00;
                    seen_function_reg <= 8'h00;
                    seen_count_reg    <= 8'h00;
                end
                else
                begin
                    crc_reg           <= crc_next;
                    seen_device_reg   <= seen_device_next;
                    seen_function_reg <= seen_function_next;
                    seen_count_reg    <= seen_count_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            a_item_reg <= in_data;
    end

    a_index_capped: assert property (@(posedge clk) disable iff (!rst_n)
        byte_index_reg <= INDEX_CAP)
        else $error("byte index past cap");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        a_fire && a_item_reg.frame_end |=> byte_index_reg == 8'd0 && crc_reg == CRC_SEED)
        else $error("frame state not cleared after frame end");

    a_status_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.result_kind == KIND_STATUS |-> a_item_reg.frame_end)
        else $error("status result without frame end");

endmodule

`default_nettype wire

@@ rtl/mrc_out_skid.sv @@
`timescale 1ns / 1ps
`default_nettype none

module mrc_out_skid (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push_valid,
    output logic                    push_ready,
    input  wire mrc_pkg::out_item_t push_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mrc_pkg::out_item_t      out_data
);
    import mrc_pkg::*;

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t main_reg;
    out_item_t skid_reg;
    logic      push;
    logic      pop;
    logic      load_main;
    logic      load_skid;
    logic      move_skid;

    assign push_ready = !skid_valid_reg;
    assign push       = push_valid && push_ready;
    assign pop        = main_valid_reg && out_ready;

    // a push goes straight to the output register when it frees up this cycle
    assign move_skid = skid_valid_reg && pop;
    assign load_main = push && (!main_valid_reg || pop);
    assign load_skid = push && main_valid_reg && !pop;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (move_skid)
            skid_valid_next = 1'b0;
        else if (load_main)
            main_valid_next = 1'b1;
        else if (load_skid)
            skid_valid_next = 1'b1;
        else if (pop)
            main_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move_skid)
            main_reg <= skid_reg;
        else if (load_main)
            main_reg <= push_data;
        if (load_skid)
            skid_reg <= push_data;
    end

    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid entry without output entry");

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> !push)
        else $error("transfer into full skid stage");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && pop |=> main_valid_reg && !skid_valid_reg)
        else $error("skid entry lost on drain");

endmodule

`default_nettype wire
